// ===== rtl/lbs_pkg.sv =====
package lbs_pkg;

  localparam int unsigned Joints     = 64;
  localparam int unsigned Vertices   = 4096;
  localparam int unsigned JointW     = 6;
  localparam int unsigned VertexW    = 12;
  localparam int unsigned JmemDepth  = Joints * 4;
  localparam int unsigned JmemAw     = $clog2(JmemDepth);
  localparam int unsigned VmemAw     = $clog2(Vertices);
  localparam int unsigned ClearCount = Vertices;

  typedef enum logic [1:0] {
    OpLoadJoint = 2'd0,
    OpLoadLocal = 2'd1,
    OpAccum     = 2'd2,
    OpEmit      = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [JointW-1:0]  joint;
    logic [1:0]         row;
    logic [VertexW-1:0] vertex;
    logic [16:0]        weight;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
  } in_word_t;

  typedef struct packed {
    logic [VertexW-1:0] out_vertex;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;   // latch input word
    logic       wr_joint;  // write joint row
    logic       wr_local;  // write local row
    logic       clr_wr;    // clear accumulator at clr_addr
    logic [VmemAw-1:0] clr_addr;
    logic       rd;        // read joint row; on row 0 also read acc
    logic [1:0] idx;       // row index for the sweep
    logic       mac;       // product row ready, start dot
    logic       sum;       // register the rounded row dot
    logic       fin;       // row dot done, apply to result
    logic       acc_wr;    // write accumulator back
    logic       emit;      // present result
  } lbs_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       in_range;
  } lbs_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== rtl/lbs_ctrl.sv =====
module lbs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  lbs_pkg::lbs_sts_t  sts_i,
  output logic               busy_o,
  output lbs_pkg::lbs_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StClear, StIdle, StDecode, StRead, StMul, StSum, StScale, StWrite
  } state_e;

  state_e state_q;
  logic [lbs_pkg::VmemAw:0] clr_q;
  logic [1:0] idx_q;
  logic [1:0] op_q;

  assign busy_o = (state_q != StIdle);

  always_comb begin
    cmd_o = '0;
    cmd_o.capture  = (state_q == StIdle) && start_i;
    cmd_o.clr_wr   = (state_q == StClear);
    cmd_o.clr_addr = clr_q[lbs_pkg::VmemAw-1:0];
    cmd_o.idx      = idx_q;
    cmd_o.wr_joint = (state_q == StDecode) && (sts_i.opcode == lbs_pkg::OpLoadJoint) &&
                     sts_i.in_range;
    cmd_o.wr_local = (state_q == StDecode) && (sts_i.opcode == lbs_pkg::OpLoadLocal);
    cmd_o.rd       = (state_q == StRead);
    cmd_o.mac      = (state_q == StMul);
    cmd_o.sum      = (state_q == StSum);
    cmd_o.fin      = (state_q == StScale);
    cmd_o.acc_wr   = (state_q == StWrite) && (op_q == lbs_pkg::OpAccum);
    cmd_o.emit     = (state_q == StWrite) && (op_q == lbs_pkg::OpEmit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      idx_q   <= '0;
      op_q    <= '0;
    end else begin
      case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (lbs_pkg::VmemAw+1)'(lbs_pkg::ClearCount - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (start_i) state_q <= StDecode;
        end
        StDecode: begin
          op_q  <= sts_i.opcode;
          idx_q <= '0;
          if ((sts_i.opcode == lbs_pkg::OpAccum && sts_i.in_range) ||
              sts_i.opcode == lbs_pkg::OpEmit) begin
            state_q <= StRead;
          end else begin
            state_q <= StIdle;
          end
        end
        StRead:  state_q <= StMul;
        StMul:   state_q <= StSum;
        StSum:   state_q <= StScale;
        StScale: begin
          idx_q <= idx_q + 1'b1;
          state_q <= (idx_q == 2'd3) ? StWrite : StRead;
        end
        StWrite: state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  // op_q is only sampled after decode; decode reads opcode from status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && start_i) |=> state_q == StDecode)
    else $error("start not taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> $past(state_q) == StScale)
    else $error("emit out of sequence");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.acc_wr && cmd_o.emit))
    else $error("write and emit together");

endmodule

// ===== rtl/lbs_datapath.sv =====
module lbs_datapath (
  input  logic                clk_i,
  input  lbs_pkg::in_word_t   in_i,
  input  lbs_pkg::lbs_cmd_t   cmd_i,
  output lbs_pkg::lbs_sts_t   sts_o,
  output logic                valid_o,
  output lbs_pkg::out_word_t  out_o
);

  lbs_pkg::in_word_t in_q;
  logic [127:0] jmem [lbs_pkg::JmemDepth];
  logic [31:0]  acc_mem [lbs_pkg::Vertices][4];
  logic [127:0] lmat_q [4];
  logic [127:0] row_q;
  logic signed [31:0] accv_q [4];
  logic signed [31:0] res_q [4];
  logic signed [63:0] prod_q [4];
  logic [lbs_pkg::VmemAw-1:0] vaddr;
  logic [lbs_pkg::JmemAw-1:0] jaddr;
  logic signed [31:0] row_e [4];
  logic signed [65:0] dot_sum;
  logic signed [31:0] dot;
  logic signed [31:0] dot_q;
  logic signed [49:0] scl;
  logic signed [33:0] scl_r;
  logic valid_q;

  assign vaddr = in_q.vertex[lbs_pkg::VmemAw-1:0];
  assign sts_o.opcode = in_q.opcode;
  assign sts_o.in_range = (32'(in_q.joint) < lbs_pkg::Joints) &&
                          (in_q.opcode != lbs_pkg::OpAccum ||
                           32'(in_q.vertex) < lbs_pkg::Vertices);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_i;
    if (cmd_i.wr_joint) jmem[jaddr] <= {in_q.c0, in_q.c1, in_q.c2, in_q.c3};
    if (cmd_i.rd) row_q <= jmem[{in_q.joint[lbs_pkg::JointW-1:0], cmd_i.idx}];
  end

  assign jaddr = {in_q.joint[lbs_pkg::JointW-1:0], in_q.row};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_local) lmat_q[in_q.row] <= {in_q.c0, in_q.c1, in_q.c2, in_q.c3};
  end

  // accumulator store: one row of four words per vertex
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      for (int k = 0; k < 4; k++) acc_mem[cmd_i.clr_addr][k] <= '0;
    end else if (cmd_i.acc_wr) begin
      for (int k = 0; k < 4; k++) acc_mem[vaddr][k] <= res_q[k];
    end else if (cmd_i.emit) begin
      for (int k = 0; k < 4; k++) acc_mem[vaddr][k] <= '0;
    end
    if (cmd_i.rd && cmd_i.idx == 2'd0) begin
      for (int k = 0; k < 4; k++) accv_q[k] <= acc_mem[vaddr][k];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      row_e[k] = (in_q.opcode == lbs_pkg::OpEmit) ? lmat_q[cmd_i.idx][127-32*k -: 32]
                                                   : row_q[127-32*k -: 32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= row_e[k] * ((in_q.opcode == lbs_pkg::OpEmit) ? accv_q[k] :
          (k == 0) ? in_q.c0 : (k == 1) ? in_q.c1 : (k == 2) ? in_q.c2 : in_q.c3);
      end
    end
  end

  always_comb begin
    dot_sum = 66'(prod_q[0]) + 66'(prod_q[1]) + 66'(prod_q[2]) + 66'(prod_q[3])
              + 66'sd32768;
    dot = lbs_pkg::sat32(dot_sum >>> 16);
    scl = dot_q * $signed({1'b0, in_q.weight});
    scl_r = 34'((scl + 50'sd32768) >>> 16);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) dot_q <= dot;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      if (in_q.opcode == lbs_pkg::OpEmit) begin
        res_q[cmd_i.idx] <= (32'(in_q.vertex) < lbs_pkg::Vertices) ? dot_q : '0;
      end else begin
        res_q[cmd_i.idx] <= lbs_pkg::sat32(66'(accv_q[cmd_i.idx]) + 66'(scl_r));
      end
    end
  end

  always_ff @(posedge clk_i) valid_q <= cmd_i.emit;
  assign valid_o = cmd_i.emit;

  assign out_o.out_vertex = in_q.vertex;
  assign out_o.out_x = res_q[0];
  assign out_o.out_y = res_q[1];
  assign out_o.out_z = res_q[2];
  assign out_o.out_w = res_q[3];

  assert property (@(posedge clk_i) cmd_i.emit |-> !$past(cmd_i.emit))
    else $error("double emit");
  assert property (@(posedge clk_i) valid_q |-> !cmd_i.emit)
    else $error("emit back to back");
  assert property (@(posedge clk_i) cmd_i.acc_wr |-> in_q.opcode == lbs_pkg::OpAccum)
    else $error("accumulate write on wrong op");

endmodule

// ===== rtl/linear_blend_skinning_top.sv =====
// Linear blend skinning engine, signed Q16.16.
// Drive in_i and raise start_i; the word is taken at an edge where busy_o is
// low. Opcodes: load joint row, load local row, accumulate link, emit vertex.
// Loads are written in the decode state, after which busy_o falls. Accumulate and emit run
// the four matrix rows through one shared 4-lane multiply and adder tree,
// each row passing read, multiply, sum and round, then scale and apply (emit
// applies the unscaled row dot).
// An emit raises out_valid_o for exactly one cycle, in the write state after the
// last row, with out_o holding the vertex index and the transformed
// vector; the receiver cannot stall it.
// Accumulators of out-of-range vertices are never touched; their emit gives 0.
// After reset the accumulator store is cleared one vertex per cycle, which
// holds busy_o high until all 4096 vertices are cleared.
// Joint and local matrices are undefined until loaded.
module linear_blend_skinning_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  lbs_pkg::in_word_t  in_i,
  output logic               busy_o,
  output logic               out_valid_o,
  output lbs_pkg::out_word_t out_o
);

  lbs_pkg::lbs_cmd_t cmd;
  lbs_pkg::lbs_sts_t sts;

  lbs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  lbs_datapath u_dp (
    .clk_i  (clk_i),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .valid_o(out_valid_o),
    .out_o  (out_o)
  );

endmodule
